// ----- rtl/palb_pkg.sv -----
// shared types, codes and preset tables for the palette blend / nearest remap block
// no dependencies; imported by every module of the block
package palb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CFG_TABLE_SELECT     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RECT_LEFT_COLUMN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECT_COLUMNS     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RECT_TOP         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RECT_LINES       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SURFACE_WIDTH    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SURFACE_HEIGHT   = 3'd6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  entry_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  pixel_value;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       was_translated;
  } res_t;

  typedef struct packed {
    logic [2:0]         table_select;
    logic signed [10:0] rect_left_column;
    logic [10:0]        rect_columns;
    logic signed [12:0] rect_top;
    logic [12:0]        rect_lines;
    logic [12:0]        surface_width;
    logic [12:0]        surface_height;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_RD_TGT,
    ST_MIX,
    ST_SEARCH,
    ST_DONE
  } palb_state_e;

  typedef enum logic [1:0] {
    RD_PIX,
    RD_TGT,
    RD_ZERO,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    load;
    logic    clip_en;
    logic    cap_pix;
    logic    mix_en;
    logic    cmp_en;
    logic    out_en;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic in_rect;
    logic last;
  } sts_t;

  function automatic logic [7:0] preset_target(input logic [2:0] sel);
    logic [7:0] t;
    unique case (sel)
      3'd4:    t = 8'd106;
      default: t = 8'd0;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] preset_blend(input logic [2:0] sel);
    logic [5:0] b;
    unique case (sel)
      3'd1:    b = 6'd40;
      3'd2:    b = 6'd30;
      3'd3:    b = 6'd20;
      3'd4:    b = 6'd35;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/palb_cfg.sv -----
// configuration register file: table preset, clip rectangle and surface size
// depends on palb_pkg
module palb_cfg import palb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TABLE_SELECT:     cfg_d.table_select     = cfg_data_i[2:0];
        CFG_RECT_LEFT_COLUMN: cfg_d.rect_left_column = cfg_data_i[10:0];
        CFG_RECT_COLUMNS:     cfg_d.rect_columns     = cfg_data_i[10:0];
        CFG_RECT_TOP:         cfg_d.rect_top         = cfg_data_i;
        CFG_RECT_LINES:       cfg_d.rect_lines       = cfg_data_i;
        CFG_SURFACE_WIDTH:    cfg_d.surface_width    = cfg_data_i;
        CFG_SURFACE_HEIGHT:   cfg_d.surface_height   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_select     <= 3'd1;
      cfg_q.rect_left_column <= '0;
      cfg_q.rect_columns     <= '0;
      cfg_q.rect_top         <= '0;
      cfg_q.rect_lines       <= '0;
      cfg_q.surface_width    <= 13'd320;
      cfg_q.surface_height   <= 13'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/palb_ctrl.sv -----
// sequencer: clip check, palette reads, blend and the palette search
// depends on palb_pkg; drives palb_dp through cmd_t, watches sts_t
module palb_ctrl import palb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  palb_state_e state_q, state_d;
  logic        accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept && op_i == OP_PIXEL) state_d = ST_CLIP;
      ST_CLIP:   state_d = sts_i.in_rect ? ST_RD_TGT : ST_DONE;
      ST_RD_TGT: state_d = ST_MIX;
      ST_MIX:    state_d = ST_SEARCH;
      ST_SEARCH: if (sts_i.last) state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_PIX;
    cmd_o.accept = accept;
    cmd_o.load   = accept && op_i == OP_LOAD;
    unique case (state_q)
      ST_IDLE: ;
      ST_CLIP: begin
        cmd_o.clip_en = 1'b1;
        cmd_o.rd_sel  = RD_PIX;
      end
      ST_RD_TGT: begin
        cmd_o.cap_pix = 1'b1;
        cmd_o.rd_sel  = RD_TGT;
      end
      ST_MIX: begin
        cmd_o.mix_en = 1'b1;
        cmd_o.rd_sel = RD_ZERO;
      end
      ST_SEARCH: begin
        cmd_o.cmp_en = 1'b1;
        cmd_o.rd_sel = RD_NEXT;
      end
      ST_DONE: cmd_o.out_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/palb_dp.sv -----
// datapath: request register, palette memory, clip test, blend and distance search
// depends on palb_pkg; sequenced by palb_ctrl
module palb_dp import palb_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cfg_t cfg_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned AW        = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0]  Entries9  = 9'(PALETTE_ENTRIES);
  localparam logic [7:0]  LastEntry = 8'(PALETTE_ENTRIES - 1);

  req_t        req_q;
  logic [23:0] mem_q [PALETTE_ENTRIES];
  logic [23:0] rd_data_q;
  logic [7:0]  rd_addr, tag_q;
  logic        rd_ok, ok_q;
  logic [23:0] rd_color;
  logic        wr_en;

  logic [23:0] pix_q;
  logic [23:0] mix_d, mix_q;
  logic        in_rect, in_rect_q;
  logic [9:0]  l1_dist;
  logic [9:0]  best_dist_q;
  logic [7:0]  best_idx_q;
  logic        valid_q;
  res_t        res_q;

  function automatic logic [7:0] blend_ch(input logic [7:0] o, input logic [7:0] t,
                                          input logic [5:0] b);
    logic signed [15:0] diff;
    logic signed [15:0] prod;
    logic signed [15:0] sum;
    diff = signed'({8'b0, t}) - signed'({8'b0, o});
    prod = diff * signed'({10'b0, b});
    // arithmetic shift rounds toward minus infinity
    sum  = signed'({8'b0, o}) + (prod >>> 6);
    return sum[7:0];
  endfunction

  function automatic logic [9:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? {2'b0, a - b} : {2'b0, b - a};
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= req_i;
  end

  // palette memory, one write and one registered read per cycle
  assign wr_en = cmd_i.load && ({1'b0, req_i.entry_index} < Entries9);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PIX:  rd_addr = req_q.pixel_value;
      RD_TGT:  rd_addr = preset_target(cfg_i.table_select);
      RD_ZERO: rd_addr = '0;
      RD_NEXT: rd_addr = tag_q + 8'd1;
      default: rd_addr = '0;
    endcase
  end

  assign rd_ok = ({1'b0, rd_addr} < Entries9);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[req_i.entry_index[AW-1:0]] <= {req_i.red, req_i.green, req_i.blue};
    rd_data_q <= mem_q[rd_addr[AW-1:0]];
    tag_q     <= rd_addr;
    ok_q      <= rd_ok;
  end

  // indexes past the palette read as black
  assign rd_color = ok_q ? rd_data_q : '0;

  // clip test; all coordinate compares signed at 16 bits
  always_comb begin
    logic signed [15:0] left, right, top, bottom, px, py;
    left    = signed'({{5{cfg_i.rect_left_column[10]}}, cfg_i.rect_left_column}) <<< 2;
    right   = left + signed'({3'b0, cfg_i.rect_columns, 2'b00});
    top     = signed'({{3{cfg_i.rect_top[12]}}, cfg_i.rect_top});
    bottom  = top + signed'({3'b0, cfg_i.rect_lines});
    px      = signed'({4'b0, req_q.pixel_x});
    py      = signed'({4'b0, req_q.pixel_y});
    in_rect = (cfg_i.rect_columns != '0) && (cfg_i.rect_lines != '0) &&
              (px >= left) && (px < right) && (px < signed'({3'b0, cfg_i.surface_width})) &&
              (py >= top) && (py < bottom) && (py < signed'({3'b0, cfg_i.surface_height}));
  end

  always_comb begin
    logic [5:0] b;
    b     = preset_blend(cfg_i.table_select);
    mix_d = {blend_ch(pix_q[23:16], rd_color[23:16], b),
             blend_ch(pix_q[15:8],  rd_color[15:8],  b),
             blend_ch(pix_q[7:0],   rd_color[7:0],   b)};
  end

  assign l1_dist = abs_diff(rd_color[23:16], mix_q[23:16]) +
                   abs_diff(rd_color[15:8],  mix_q[15:8]) +
                   abs_diff(rd_color[7:0],   mix_q[7:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clip_en) in_rect_q <= in_rect;
    if (cmd_i.cap_pix) pix_q <= rd_color;
    if (cmd_i.mix_en) begin
      mix_q       <= mix_d;
      best_dist_q <= 10'd255;
      best_idx_q  <= '0;
    end else if (cmd_i.cmp_en && l1_dist < best_dist_q) begin
      best_dist_q <= l1_dist;
      best_idx_q  <= tag_q;
    end
    if (cmd_i.out_en) begin
      res_q.pixel_out      <= in_rect_q ? best_idx_q : req_q.pixel_value;
      res_q.was_translated <= in_rect_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.out_en;
    end
  end

  assign sts_o.in_rect = in_rect;
  assign sts_o.last    = (tag_q == LastEntry);
  assign done_o        = valid_q;
  assign res_o         = res_q;

endmodule

// ----- rtl/palette_blend_nearest_remap.sv -----
// palette blend and nearest-colour remap; a load request writes at acceptance, busy stays low
// a pixel outside the clip rectangle goes from clip to done and then strobes its result
// a pixel inside adds target read, blend, search: one palette memory read per entry searched
// the next request is taken in the cycle its result strobe shows; the receiver cannot stall
// reset clears the sequencer and result strobe, presets config; palette contents undefined
module palette_blend_nearest_remap import palb_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  req_t                req_i,
  output logic                busy_o,
  output logic                done_o,
  output res_t                res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  palb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  palb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (req_i.operation),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  palb_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

// ----- rtl/palb_chk.sv -----
// port-level checker for the palette remap top level, attached by bind
// depends on palb_pkg
module palb_chk import palb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic done_o
);

  // a load request never makes the block busy
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.operation == OP_LOAD |=> !busy_o)
    else $error("load request made the block busy");

  // a pixel request always goes busy
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.operation == OP_PIXEL |=> busy_o)
    else $error("pixel request did not start");

  // the end of a pixel request shows its result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("pixel request finished without result");

  // a result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result strobe outside request end");

endmodule

bind palette_blend_nearest_remap palb_chk u_palb_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
